@@ src/ccd_pkg.sv @@
package ccd_pkg;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_TOUCH  = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_INVAL  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_DIS  = 2'd2,
    ST_DONE = 2'd3
  } status_t;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_CHUNK  = 1'b1;
  localparam logic [4:0] CHUNK_LOG2_RESET = 5'd12;

  typedef struct packed {
    action_t     action;
    logic [31:0] file_cell;
    logic [31:0] file_volume;
    logic [31:0] file_vnode;
    logic [31:0] file_unique;
    logic [39:0] byte_offset;
    logic [31:0] data_version;
    logic [9:0]  entry_slot;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  slot_out;
    logic [31:0] version_out;
  } rsp_t;

  // One directory entry: used flag and full tag
  typedef struct packed {
    logic        used;
    logic [63:0] cell_volume;
    logic [63:0] vnode_unique;
    logic [31:0] chunk;
  } tag_t;

endpackage

@@ src/chunk_cache_directory_lru_core.sv @@
// Chunk cache directory with least-recently-used replacement.
//
// Requests enter on req when start is high and busy is low. Each request gives
// exactly one result on rsp, marked by a one-cycle done strobe; the receiver
// cannot stall, so the result must be taken in that cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once. The user
// must issue them only while the block is idle; the block does not enforce it.
//
// Tags, versions and the recency list (a doubly linked list held in next and
// prev memories, with head and tail registers) live in single-port-read RAMs.
// Request handling:
//   update, disabled or out-of-range requests: finish straight from idle
//   touch, invalidate: list unlink and relink, skipped when already in place
//   get: a linear tag scan, one slot per cycle, set by the tag RAM read port;
//   a miss fills the least recent slot at the end of the scan.
// One request is in flight at a time.
// After reset a clearing pass over every slot empties the tags and builds
// the recency list; busy stays high during it.
module chunk_cache_directory_lru_core #(
  parameter int ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ccd_pkg::req_t req,
  output logic          done,
  output ccd_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [4:0]    cfg_data
);
  import ccd_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int TW = $bits(tag_t);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SCAN, S_HITV, S_LRD, S_LW1, S_LW2
  } state_t;

  state_t        state;
  logic          cache_enable;
  logic [4:0]    chunk_size_log2;
  req_t          req_q;
  logic [31:0]   chunk_q;
  logic [AW-1:0] cur;
  logic          to_tail;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW:0]   cnt;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;

  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  tag_t          tag_wdata;
  logic [AW-1:0] tag_raddr;
  tag_t          tag_rdata;
  logic          ver_we;
  logic [AW-1:0] ver_waddr;
  logic [31:0]   ver_wdata;
  logic [31:0]   ver_rdata;
  logic          nxt_we;
  logic [AW-1:0] nxt_waddr;
  logic [AW-1:0] nxt_wdata;
  logic [AW-1:0] nxt_rdata;
  logic          prv_we;
  logic [AW-1:0] prv_waddr;
  logic [AW-1:0] prv_wdata;
  logic [AW-1:0] prv_rdata;

  logic [31:0]   slot_ext;
  logic [AW-1:0] slot_idx;
  logic          slot_ok;
  logic          accept;
  tag_t          key;
  logic          hit;
  logic          scan_end;
  logic [31:0]   cur_ext;
  status_t       idle_status;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = 32'(req.entry_slot);
  assign slot_idx = slot_ext[AW-1:0];
  assign slot_ok  = slot_ext < 32'(ENTRIES);
  assign cur_ext  = 32'(cur);

  // Report disabled for get, touch and update while the cache is off
  always_comb begin
    idle_status = ST_DONE;
    if (!cache_enable && req.action != ACT_INVAL) begin
      idle_status = ST_DIS;
    end
  end

  // Build the search key from the held request
  assign key = '{used: 1'b1,
                 cell_volume: {req_q.file_cell, req_q.file_volume},
                 vnode_unique: {req_q.file_vnode, req_q.file_unique},
                 chunk: chunk_q};

  assign hit      = cmp_valid && (tag_rdata == key);
  assign scan_end = cmp_valid && (cmp_idx == AW'(ENTRIES - 1));

  // Drive the memory ports
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = cur;
    tag_wdata = key;
    tag_raddr = cnt[AW-1:0];
    ver_we    = 1'b0;
    ver_waddr = head;
    ver_wdata = req_q.data_version;
    nxt_we    = 1'b0;
    nxt_waddr = cur;
    nxt_wdata = head;
    prv_we    = 1'b0;
    prv_waddr = cur;
    prv_wdata = tail;
    unique case (state)
      S_CLR: begin
        tag_we    = 1'b1;
        tag_waddr = cnt[AW-1:0];
        tag_wdata = '0;
        nxt_we    = 1'b1;
        nxt_waddr = cnt[AW-1:0];
        nxt_wdata = cnt[AW-1:0] + AW'(1);
        prv_we    = 1'b1;
        prv_waddr = cnt[AW-1:0];
        prv_wdata = cnt[AW-1:0] - AW'(1);
      end
      S_IDLE: begin
        if (accept && slot_ok) begin
          if (req.action == ACT_UPDATE && cache_enable) begin
            ver_we    = 1'b1;
            ver_waddr = slot_idx;
            ver_wdata = req.data_version;
          end
          if (req.action == ACT_INVAL) begin
            tag_we    = 1'b1;
            tag_waddr = slot_idx;
            tag_wdata = '0;
          end
        end
      end
      S_SCAN: begin
        // allocate the least recent slot on a miss
        if (!hit && scan_end) begin
          tag_we    = 1'b1;
          tag_waddr = head;
          ver_we    = 1'b1;
        end
      end
      S_HITV: ;
      S_LRD: ;
      S_LW1: begin
        // unlink cur: prv_rdata and nxt_rdata are its neighbors
        if (cur != head) begin
          nxt_we    = 1'b1;
          nxt_waddr = prv_rdata;
          nxt_wdata = nxt_rdata;
        end
        if (cur != tail) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_rdata;
          prv_wdata = prv_rdata;
        end
      end
      S_LW2: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (to_tail) begin
          prv_waddr = cur;
          prv_wdata = tail;
          nxt_waddr = tail;
          nxt_wdata = cur;
        end else begin
          nxt_waddr = cur;
          nxt_wdata = head;
          prv_waddr = head;
          prv_wdata = cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLR;
      cache_enable    <= 1'b0;
      chunk_size_log2 <= CHUNK_LOG2_RESET;
      cnt             <= '0;
      cmp_valid       <= 1'b0;
      head            <= '0;
      tail            <= AW'(ENTRIES - 1);
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          cache_enable <= cfg_data[0];
        end else begin
          chunk_size_log2 <= cfg_data;
        end
      end
      unique case (state)
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_q   <= req;
            chunk_q <= 32'(req.byte_offset >> chunk_size_log2);
            cur     <= slot_idx;
            rsp     <= '{status: idle_status, slot_out: '0, version_out: '0};
            unique case (req.action)
              ACT_GET: begin
                if (!cache_enable) begin
                  done <= 1'b1;
                end else begin
                  cnt       <= '0;
                  cmp_valid <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              ACT_TOUCH, ACT_INVAL: begin
                to_tail <= (req.action == ACT_TOUCH);
                if (req.action == ACT_TOUCH && !cache_enable) begin
                  done <= 1'b1;
                end else if (!slot_ok) begin
                  done <= 1'b1;
                end else begin
                  state <= S_LRD;
                end
              end
              ACT_UPDATE: begin
                done <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          cnt       <= cnt + 1'b1;
          cmp_valid <= (cnt < (AW+1)'(ENTRIES));
          cmp_idx   <= cnt[AW-1:0];
          if (hit) begin
            cur   <= cmp_idx;
            state <= S_HITV;
          end else if (scan_end) begin
            cur     <= head;
            to_tail <= 1'b1;
            rsp     <= '{status: ST_MISS, slot_out: 10'(32'(head)),
                         version_out: req_q.data_version};
            state   <= S_LRD;
          end
        end
        S_HITV: begin
          rsp   <= '{status: ST_HIT, slot_out: cur_ext[9:0], version_out: ver_rdata};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_LRD: begin
          // already in place: nothing to move
          if ((to_tail && cur == tail) || (!to_tail && cur == head)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LW1;
          end
        end
        S_LW1: begin
          if (cur == head) begin
            head <= nxt_rdata;
          end
          if (cur == tail) begin
            tail <= prv_rdata;
          end
          state <= S_LW2;
        end
        S_LW2: begin
          if (to_tail) begin
            tail <= cur;
          end else begin
            head <= cur;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ccd_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  ccd_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ver (
    .clk(clk), .we(ver_we), .waddr(ver_waddr), .wdata(ver_wdata),
    .raddr(cmp_idx), .rdata(ver_rdata)
  );

  ccd_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(cur), .rdata(nxt_rdata)
  );

  ccd_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(cur), .rdata(prv_rdata)
  );

endmodule

@@ src/ccd_ram.sv @@
module ccd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/tb_chunk_cache_directory_lru_core.sv @@
module tb_chunk_cache_directory_lru_core;
  import ccd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 1024;
  localparam int STALL_LIMIT = 20000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       req;
  logic       done;
  rsp_t       rsp;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;

  chunk_cache_directory_lru_core #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow directory state
  logic        dir_enable;
  logic [4:0]  dir_chunk_log2;
  logic        dir_used [ENTRIES];
  logic [63:0] dir_cv [ENTRIES];
  logic [63:0] dir_vu [ENTRIES];
  logic [31:0] dir_chunk [ENTRIES];
  logic [31:0] dir_version [ENTRIES];
  int          lru_list [ENTRIES];

  req_t pending_reqs [$];
  int   pending_gaps [$];
  rsp_t expected_rsps [$];
  int   fail_count;
  int   idle_cycles;
  int   gap_left;
  bit   feeding;
  logic busy_at_edge;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int lru_pos(int slot);
    for (int p = 0; p < ENTRIES; p++)
      if (lru_list[p] == slot) return p;
    return 0;
  endfunction

  function automatic void make_recent(int slot);
    int p;
    p = lru_pos(slot);
    for (; p + 1 < ENTRIES; p++) lru_list[p] = lru_list[p + 1];
    lru_list[ENTRIES - 1] = slot;
  endfunction

  function automatic void make_oldest(int slot);
    int p;
    p = lru_pos(slot);
    for (; p > 0; p--) lru_list[p] = lru_list[p - 1];
    lru_list[0] = slot;
  endfunction

  // Compute the directory response and advance the shadow state
  function automatic rsp_t lookup_directory(req_t r);
    rsp_t        o;
    logic [31:0] chunk;
    logic [63:0] cv, vu;
    int          s;
    bit          hit;
    o = '0;
    o.status = ST_DONE;
    cv = {r.file_cell, r.file_volume};
    vu = {r.file_vnode, r.file_unique};
    case (r.action)
      ACT_GET: begin
        if (!dir_enable) begin
          o.status = ST_DIS;
        end else begin
          chunk = 32'(r.byte_offset >> dir_chunk_log2);
          hit = 0;
          for (s = 0; s < ENTRIES; s++)
            if (dir_used[s] && dir_cv[s] == cv && dir_vu[s] == vu &&
                dir_chunk[s] == chunk) begin
              hit = 1;
              break;
            end
          if (hit) begin
            o.status = ST_HIT;
          end else begin
            s = lru_list[0];
            dir_used[s] = 1;
            dir_cv[s] = cv;
            dir_vu[s] = vu;
            dir_chunk[s] = chunk;
            dir_version[s] = r.data_version;
            make_recent(s);
            o.status = ST_MISS;
          end
          o.slot_out = 10'(s);
          o.version_out = dir_version[s];
        end
      end
      ACT_TOUCH, ACT_UPDATE: begin
        if (!dir_enable) o.status = ST_DIS;
        else if (r.entry_slot < ENTRIES) begin
          if (r.action == ACT_TOUCH) make_recent(int'(r.entry_slot));
          else dir_version[r.entry_slot] = r.data_version;
        end
      end
      default: begin
        if (r.entry_slot < ENTRIES) begin
          dir_used[r.entry_slot] = 0;
          dir_cv[r.entry_slot] = '0;
          dir_vu[r.entry_slot] = '0;
          dir_chunk[r.entry_slot] = '0;
          make_oldest(int'(r.entry_slot));
        end
      end
    endcase
    return o;
  endfunction

  // Driver: present queued requests after a random gap
  always @(negedge clk) begin
    if (!rst && feeding) begin
      if (start && !busy_at_edge) begin
        start <= 1'b0;
      end else if (!start && pending_reqs.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          req <= pending_reqs.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Capture acceptance and check results at the rising edge
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(lookup_directory(req));
        gap_left <= pending_gaps.size() > 0 ? pending_gaps.pop_front() : 0;
      end
      if (done) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with none expected, actual %p", $time, rsp);
          fail_count++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e !== rsp) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
            fail_count++;
          end
        end
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // File identifiers drawn from a small pool so gets hit often
  logic [127:0] id_pool [8];

  function automatic req_t rand_req(bit noise);
    req_t r;
    logic [127:0] id;
    r.action = action_t'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 6) r.action = ACT_GET;
    id = noise ? {$urandom, $urandom, $urandom, $urandom} : id_pool[$urandom_range(0, 7)];
    {r.file_cell, r.file_volume, r.file_vnode, r.file_unique} = id;
    r.byte_offset = noise ? {8'($urandom), $urandom}
                          : 40'($urandom_range(0, 7)) << $urandom_range(9, 16);
    r.data_version = $urandom;
    r.entry_slot = $urandom_range(0, 9) < 7
                   ? 10'(lru_list[$urandom_range(ENTRIES - 16, ENTRIES - 1)])
                   : 10'($urandom);
    return r;
  endfunction

  task automatic queue_req(req_t r, bit allow_gap);
    pending_reqs.push_back(r);
    pending_gaps.push_back(allow_gap ? $urandom_range(0, 12) : 0);
  endtask

  task automatic drain_requests();
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write one configuration register at idle
  task automatic write_reg(logic idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENABLE) dir_enable = val[0];
    else dir_chunk_log2 = val;
  endtask

  initial begin
    req_t r;
    int   phase_log2 [4];
    phase_log2[0] = 9;
    phase_log2[1] = 16;
    phase_log2[2] = 0;
    phase_log2[3] = 31;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    gap_left = 0;
    feeding = 1'b0;
    dir_enable = 1'b0;
    dir_chunk_log2 = CHUNK_LOG2_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      dir_used[i] = 0;
      dir_version[i] = '0;
      dir_cv[i] = '0;
      dir_vu[i] = '0;
      dir_chunk[i] = '0;
      lru_list[i] = i;
    end
    for (int i = 0; i < 8; i++) id_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    feeding = 1'b1;

    // Disabled cache: get, touch and update report disabled, invalidate acts
    r = '0;
    for (int a = 0; a < 4; a++) begin
      r.action = action_t'(a);
      r.entry_slot = 10'd5;
      queue_req(r, 1);
    end
    drain_requests();

    // Enabled: extremes of each field, hits, misses, odd slots
    write_reg(CFG_ENABLE, 5'd1);
    r = '0;
    r.action = ACT_GET; r.data_version = '1;
    queue_req(r, 0);
    queue_req(r, 1);
    r = '1; r.action = ACT_GET;
    queue_req(r, 0);
    queue_req(r, 0);
    r.byte_offset = '0;
    queue_req(r, 1);
    r = '0; r.action = ACT_TOUCH; r.entry_slot = 10'd0;
    queue_req(r, 0);
    r.action = ACT_UPDATE; r.entry_slot = 10'd1023; r.data_version = 32'hdead_beef;
    queue_req(r, 0);
    r.action = ACT_UPDATE; r.entry_slot = 10'd0;
    queue_req(r, 0);
    r.action = ACT_GET;
    queue_req(r, 0);
    r.action = ACT_INVAL; r.entry_slot = 10'd0;
    queue_req(r, 1);
    r.action = ACT_GET;
    queue_req(r, 0);
    r.action = ACT_TOUCH; r.entry_slot = 10'd700;
    queue_req(r, 0);
    drain_requests();

    // Random phases across chunk sizes and enable settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CHUNK, ph < 4 ? 5'(phase_log2[ph]) : 5'($urandom_range(9, 16)));
      write_reg(CFG_ENABLE, ph == 4 ? 5'd0 : 5'd1);
      for (int n = 0; n < 300; n++) queue_req(rand_req($urandom_range(0, 9) < 2), n % 100 < 60);
      drain_requests();
    end

    feeding = 1'b0;
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
